FILE: hw/rtl/necir_pkg.sv
// Package for the NEC infrared frame decoder: register indexes, reset values,
// the classified pulse type passed from front to back, and the window compare.
// Depends on nothing; every other file of the decoder uses it.
`default_nettype none

package necir_pkg;

    localparam int PULSE_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int BYTE_W      = 8;
    localparam int FRAME_BITS  = 32;
    localparam int COUNT_W     = $clog2(FRAME_BITS);
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HEADER_MIN = 4'd0,
        REG_HEADER_MAX = 4'd1,
        REG_REPEAT_MIN = 4'd2,
        REG_REPEAT_MAX = 4'd3,
        REG_ONE_MIN    = 4'd4,
        REG_ONE_MAX    = 4'd5,
        REG_ZERO_MIN   = 4'd6,
        REG_ZERO_MAX   = 4'd7
    } cfg_reg_t;

    typedef enum logic {
        KIND_FRAME  = 1'b0,
        KIND_REPEAT = 1'b1
    } result_kind_t;

    localparam logic [CFG_DATA_W-1:0] HEADER_MIN_RST = 16'd4300;
    localparam logic [CFG_DATA_W-1:0] HEADER_MAX_RST = 16'd4700;
    localparam logic [CFG_DATA_W-1:0] REPEAT_MIN_RST = 16'd2050;
    localparam logic [CFG_DATA_W-1:0] REPEAT_MAX_RST = 16'd2450;
    localparam logic [CFG_DATA_W-1:0] ONE_MIN_RST    = 16'd1400;
    localparam logic [CFG_DATA_W-1:0] ONE_MAX_RST    = 16'd1900;
    localparam logic [CFG_DATA_W-1:0] ZERO_MIN_RST   = 16'd360;
    localparam logic [CFG_DATA_W-1:0] ZERO_MAX_RST   = 16'd760;

    typedef struct packed {
        logic header;
        logic repeat_code;
        logic shift;
        logic bit_value;
    } pulse_class_t;

    typedef struct packed {
        logic               receiving;
        logic [COUNT_W-1:0] bit_count;
    } back_status_t;

    function automatic logic in_window(
        input logic [PULSE_W-1:0]    w,
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi
    );
        return (w > lo) && (w < hi);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/necir_if.sv
// Handshake interfaces of the NEC infrared frame decoder: pulse input,
// result output and configuration write channel. Depends on necir_pkg.
`default_nettype none

interface necir_pulse_if;
    logic                          valid;
    logic                          ready;
    logic [necir_pkg::PULSE_W-1:0] pulse_width;

    modport source (output valid, output pulse_width, input ready);
    modport sink   (input valid, input pulse_width, output ready);
endinterface

interface necir_result_if;
    logic                         valid;
    logic                         ready;
    logic                         result_kind;
    logic [necir_pkg::BYTE_W-1:0] device_address;
    logic [necir_pkg::BYTE_W-1:0] command_code;

    modport source (output valid, output result_kind, output device_address,
                    output command_code, input ready);
    modport sink   (input valid, input result_kind, input device_address,
                    input command_code, output ready);
endinterface

interface necir_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [necir_pkg::CFG_INDEX_W-1:0] index;
    logic [necir_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/necir_front.sv
// Front of the NEC decoder: holds the window registers, accepts pulse items
// and classifies each one against the windows. Depends on necir_pkg, necir_if.
`default_nettype none

module necir_front (
    input  logic                    clk,
    input  logic                    rst_n,
    necir_pulse_if.sink             pulse,
    necir_cfg_if.sink               cfg,
    input  logic                    queue_full,
    output logic                    push,
    output necir_pkg::pulse_class_t cls
);
    import necir_pkg::*;

    logic [CFG_DATA_W-1:0] header_min_reg, header_max_reg;
    logic [CFG_DATA_W-1:0] repeat_min_reg, repeat_max_reg;
    logic [CFG_DATA_W-1:0] one_min_reg, one_max_reg;
    logic [CFG_DATA_W-1:0] zero_min_reg, zero_max_reg;
    logic                  hit_header, hit_repeat, hit_one, hit_zero;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_min_reg <= HEADER_MIN_RST;
            header_max_reg <= HEADER_MAX_RST;
            repeat_min_reg <= REPEAT_MIN_RST;
            repeat_max_reg <= REPEAT_MAX_RST;
            one_min_reg    <= ONE_MIN_RST;
            one_max_reg    <= ONE_MAX_RST;
            zero_min_reg   <= ZERO_MIN_RST;
            zero_max_reg   <= ZERO_MAX_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_HEADER_MIN: header_min_reg <= cfg.data;
                REG_HEADER_MAX: header_max_reg <= cfg.data;
                REG_REPEAT_MIN: repeat_min_reg <= cfg.data;
                REG_REPEAT_MAX: repeat_max_reg <= cfg.data;
                REG_ONE_MIN:    one_min_reg    <= cfg.data;
                REG_ONE_MAX:    one_max_reg    <= cfg.data;
                REG_ZERO_MIN:   zero_min_reg   <= cfg.data;
                REG_ZERO_MAX:   zero_max_reg   <= cfg.data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        hit_header = in_window(pulse.pulse_width, header_min_reg, header_max_reg);
        hit_repeat = in_window(pulse.pulse_width, repeat_min_reg, repeat_max_reg);
        hit_one    = in_window(pulse.pulse_width, one_min_reg, one_max_reg);
        hit_zero   = in_window(pulse.pulse_width, zero_min_reg, zero_max_reg);

        cls.header      = hit_header;
        cls.repeat_code = !hit_header && hit_repeat;
        cls.shift       = hit_one || hit_zero;
        cls.bit_value   = hit_one;

        // An item that matches no window changes nothing and is dropped here.
        pulse.ready = !queue_full;
        push        = pulse.valid && !queue_full
                      && (cls.header || cls.repeat_code || cls.shift);
    end

endmodule

`default_nettype wire

FILE: hw/rtl/necir_queue.sv
// Short queue of classified pulse items between the front and the back of
// the NEC decoder. Depends on necir_pkg.
`default_nettype none

module necir_queue #(
    parameter int DEPTH = necir_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  necir_pkg::pulse_class_t push_data,
    input  logic                    pop,
    output necir_pkg::pulse_class_t head,
    output logic                    empty,
    output logic                    full
);
    import necir_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    pulse_class_t      entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == DEPTH_CNT);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/necir_back.sv
// Back of the NEC decoder: applies classified pulses to the frame shifter,
// checks complete frames and holds the result register. Depends on necir_pkg.
`default_nettype none

module necir_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  necir_pkg::pulse_class_t head,
    input  logic                    empty,
    output logic                    pop,
    necir_result_if.source          result,
    output necir_pkg::back_status_t status
);
    import necir_pkg::*;

    localparam logic [COUNT_W-1:0] LAST_BIT = COUNT_W'(FRAME_BITS - 1);

    logic                  receiving_reg, receiving_next;
    logic [COUNT_W-1:0]    bit_count_reg, bit_count_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [BYTE_W-1:0]     last_addr_reg, last_addr_next;
    logic [BYTE_W-1:0]     last_cmd_reg, last_cmd_next;
    logic                  out_valid_reg, out_valid_next;
    result_kind_t          out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0]     out_addr_reg, out_addr_next;
    logic [BYTE_W-1:0]     out_cmd_reg, out_cmd_next;
    logic                  armed, complete, frame_ok;

    assign pop                   = !empty && (!out_valid_reg || result.ready);
    assign result.valid          = out_valid_reg;
    assign result.result_kind    = out_kind_reg;
    assign result.device_address = out_addr_reg;
    assign result.command_code   = out_cmd_reg;
    assign status.receiving      = receiving_reg;
    assign status.bit_count      = bit_count_reg;

    always_comb
    begin
        receiving_next = receiving_reg;
        bit_count_next = bit_count_reg;
        frame_next     = frame_reg;
        last_addr_next = last_addr_reg;
        last_cmd_next  = last_cmd_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_kind_next  = out_kind_reg;
        out_addr_next  = out_addr_reg;
        out_cmd_next   = out_cmd_reg;

        armed    = receiving_reg || head.header;
        complete = armed && head.shift && (bit_count_reg == LAST_BIT);
        frame_ok = 1'b0;

        if (pop)
        begin
            receiving_next = armed;
            if (armed && head.shift)
            begin
                frame_next = {head.bit_value, frame_reg[FRAME_BITS-1:1]};
                if (complete)
                begin
                    bit_count_next = '0;
                    receiving_next = 1'b0;
                end
                else
                begin
                    bit_count_next = bit_count_reg + COUNT_W'(1);
                end
            end

            frame_ok = (frame_next[7:0] == ~frame_next[15:8])
                       && (frame_next[23:16] == ~frame_next[31:24]);

            if (complete && frame_ok)
            begin
                last_addr_next = frame_next[7:0];
                last_cmd_next  = frame_next[23:16];
                out_valid_next = 1'b1;
                out_kind_next  = KIND_FRAME;
                out_addr_next  = frame_next[7:0];
                out_cmd_next   = frame_next[23:16];
            end
            else if (!complete && head.repeat_code)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = KIND_REPEAT;
                out_addr_next  = last_addr_reg;
                out_cmd_next   = last_cmd_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            bit_count_reg <= '0;
            frame_reg     <= '0;
            last_addr_reg <= '0;
            last_cmd_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            receiving_reg <= receiving_next;
            bit_count_reg <= bit_count_next;
            frame_reg     <= frame_next;
            last_addr_reg <= last_addr_next;
            last_cmd_reg  <= last_cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_addr_reg <= out_addr_next;
        out_cmd_reg  <= out_cmd_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/nec_ir_frame_decoder.sv
// NEC infrared frame decoder, top level. Each pulse item carries one measured
// high-pulse width; the block reports decoded frames and repeat codes.
// The pulse channel is accepted when valid and ready are high at a clock edge.
// The front compares the width against the header, repeat, one and zero
// windows in the cycle it is accepted and pushes a classified item into a
// two-entry queue; widths that match no window are dropped there.
// The back takes one queued item per cycle while its result register is free
// or being read, shifts bits in least significant bit first and checks the
// address and command bytes against their inverses when the 32nd bit arrives.
// One pulse item per cycle is sustained while the result receiver keeps up.
// When the result receiver stalls, the output register holds its item, the
// queue fills and pulse ready drops once both queue entries are taken.
// The cfg channel is always ready; writes take effect on the next cycle and
// must only happen while the block is idle. Indexes above seven are ignored.
// Reset restores the default windows, disarms reception and clears the last
// address and command.
// Depends on necir_pkg, necir_if, necir_front, necir_queue and necir_back.
`default_nettype none

module nec_ir_frame_decoder #(
    parameter int QUEUE_DEPTH = necir_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    necir_pulse_if.sink    pulse,
    necir_result_if.source result,
    necir_cfg_if.sink      cfg
);
    import necir_pkg::*;

    pulse_class_t cls, head;
    back_status_t status;
    logic         push, pop, empty, full;

    necir_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pulse      (pulse),
        .cfg        (cfg),
        .queue_full (full),
        .push       (push),
        .cls        (cls)
    );

    necir_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cls),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    necir_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .result (result),
        .status (status)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("Classified item pushed into a full queue.");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("Back popped an empty queue.");

    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !status.receiving |-> (status.bit_count == '0))
        else $error("Bit count is nonzero while reception is disarmed.");

    a_pop_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !pop)
        else $error("Back consumed an item while the result register was stalled.");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Regression bench for nec_ir_frame_decoder: window edges first, then random frames,
// repeat codes and noise under several window settings, each result checked in order.
// Depends on necir_pkg, the necir handshake interfaces and the decoder RTL.

module testbench;
    import necir_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_WAIT      = 16;
    localparam int NUM_REGS      = 8;

    typedef struct packed {
        result_kind_t      kind;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] command;
    } decoded_t;

    logic clk;
    logic rst_n;

    necir_pulse_if  pulse_ch ();
    necir_result_if result_ch ();
    necir_cfg_if    cfg_ch ();

    nec_ir_frame_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pulse  (pulse_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    logic [CFG_DATA_W-1:0] window_reg [NUM_REGS];
    logic                  armed;
    int                    bit_total;
    logic [FRAME_BITS-1:0] frame_word;
    logic [BYTE_W-1:0]     last_addr;
    logic [BYTE_W-1:0]     last_cmd;

    decoded_t decoded_q [$];
    int       effective_count;
    int       pulse_count;
    int       mismatch_count;
    int       cycle_count;
    bit       sender_calm;
    bit       receiver_calm;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("nec_ir_frame_decoder regression: fail");
            $finish;
        end
    end

    function automatic void reset_model();
        window_reg[REG_HEADER_MIN] = HEADER_MIN_RST;
        window_reg[REG_HEADER_MAX] = HEADER_MAX_RST;
        window_reg[REG_REPEAT_MIN] = REPEAT_MIN_RST;
        window_reg[REG_REPEAT_MAX] = REPEAT_MAX_RST;
        window_reg[REG_ONE_MIN]    = ONE_MIN_RST;
        window_reg[REG_ONE_MAX]    = ONE_MAX_RST;
        window_reg[REG_ZERO_MIN]   = ZERO_MIN_RST;
        window_reg[REG_ZERO_MAX]   = ZERO_MAX_RST;
        armed      = 1'b0;
        bit_total  = 0;
        frame_word = '0;
        last_addr  = '0;
        last_cmd   = '0;
    endfunction

    function automatic bit fits_window(input logic [PULSE_W-1:0] w,
                                       input logic [CFG_DATA_W-1:0] lo,
                                       input logic [CFG_DATA_W-1:0] hi);
        return (w > lo) && (w < hi);
    endfunction

    // Returns 1 when the pulse produces a result, and advances the decoder state.
    function automatic bit decode_pulse(input logic [PULSE_W-1:0] w, output decoded_t res);
        bit repeat_hit;
        bit shifted;
        repeat_hit = 1'b0;
        shifted    = 1'b0;
        res        = '0;
        if (fits_window(w, window_reg[REG_HEADER_MIN], window_reg[REG_HEADER_MAX]))
        begin
            armed = 1'b1;
            effective_count++;
        end
        else if (fits_window(w, window_reg[REG_REPEAT_MIN], window_reg[REG_REPEAT_MAX]))
        begin
            repeat_hit = 1'b1;
            effective_count++;
        end
        if (armed)
        begin
            if (fits_window(w, window_reg[REG_ONE_MIN], window_reg[REG_ONE_MAX]))
            begin
                frame_word = {1'b1, frame_word[FRAME_BITS-1:1]};
                shifted    = 1'b1;
            end
            else if (fits_window(w, window_reg[REG_ZERO_MIN], window_reg[REG_ZERO_MAX]))
            begin
                frame_word = {1'b0, frame_word[FRAME_BITS-1:1]};
                shifted    = 1'b1;
            end
            if (shifted)
            begin
                effective_count++;
                bit_total++;
                if (bit_total == FRAME_BITS)
                begin
                    bit_total = 0;
                    armed     = 1'b0;
                    if (frame_word[7:0] == ~frame_word[15:8] &&
                        frame_word[23:16] == ~frame_word[31:24])
                    begin
                        last_addr = frame_word[7:0];
                        last_cmd  = frame_word[23:16];
                        res       = '{KIND_FRAME, last_addr, last_cmd};
                        return 1'b1;
                    end
                    return 1'b0;
                end
            end
        end
        if (repeat_hit)
        begin
            res = '{KIND_REPEAT, last_addr, last_cmd};
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [PULSE_W-1:0] pick_between(input logic [CFG_DATA_W-1:0] lo,
                                                        input logic [CFG_DATA_W-1:0] hi);
        if (int'(hi) > int'(lo) + 1)
            return $urandom_range(int'(hi) - 1, int'(lo) + 1);
        return $urandom;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_upper(input logic [CFG_DATA_W-1:0] lo);
        int hi;
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        hi = int'(lo) + $urandom_range(2, 4000);
        return (hi > 65535) ? 16'hFFFF : hi[15:0];
    endfunction

    task automatic send_pulse(input logic [PULSE_W-1:0] w);
        int       gap;
        decoded_t res;
        if ($urandom_range(0, 39) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            pulse_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pulse_ch.valid       <= 1'b1;
        pulse_ch.pulse_width <= w;
        do @(posedge clk); while (pulse_ch.ready !== 1'b1);
        pulse_count++;
        if (decode_pulse(w, res))
            decoded_q.push_back(res);
    endtask

    task automatic send_header();
        send_pulse(pick_between(window_reg[REG_HEADER_MIN], window_reg[REG_HEADER_MAX]));
    endtask

    task automatic send_repeat();
        send_pulse(pick_between(window_reg[REG_REPEAT_MIN], window_reg[REG_REPEAT_MAX]));
    endtask

    task automatic send_bit(input bit b);
        if (b)
            send_pulse(pick_between(window_reg[REG_ONE_MIN], window_reg[REG_ONE_MAX]));
        else
            send_pulse(pick_between(window_reg[REG_ZERO_MIN], window_reg[REG_ZERO_MAX]));
    endtask

    // A frame may be corrupted, cut short, or interleaved with noise, repeat codes
    // and extra headers; an extra header keeps the bits already collected.
    task automatic send_frame(input logic [BYTE_W-1:0] address, input logic [BYTE_W-1:0] command);
        logic [FRAME_BITS-1:0] word;
        int                    i;
        word = {~command, command, ~address, address};
        if ($urandom_range(0, 3) == 0)
            word[$urandom_range(0, FRAME_BITS - 1)] ^= 1'b1;
        send_header();
        for (i = 0; i < FRAME_BITS; i++)
        begin
            case ($urandom_range(0, 99))
                0, 1: send_pulse($urandom);
                2: send_header();
                3: send_repeat();
                4: break;
                default: ;
            endcase
            send_bit(word[i]);
        end
    endtask

    task automatic random_activity();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            send_frame($urandom, $urandom);
        else if (pick < 80)
            send_repeat();
        else if (pick < 90)
            send_bit($urandom_range(0, 1));
        else
            send_pulse($urandom);
    endtask

    task automatic run_mix(input int target);
        int base_effective;
        int base_pulses;
        base_effective = effective_count;
        base_pulses    = pulse_count;
        while (effective_count - base_effective < target &&
               pulse_count - base_pulses < 8 * target)
            random_activity();
    endtask

    task automatic drain_results();
        pulse_ch.valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        if (index <= REG_ZERO_MAX)
            window_reg[index] = value;
    endtask

    task automatic set_windows(input logic [CFG_DATA_W-1:0] h_lo, input logic [CFG_DATA_W-1:0] h_hi,
                               input logic [CFG_DATA_W-1:0] r_lo, input logic [CFG_DATA_W-1:0] r_hi,
                               input logic [CFG_DATA_W-1:0] o_lo, input logic [CFG_DATA_W-1:0] o_hi,
                               input logic [CFG_DATA_W-1:0] z_lo, input logic [CFG_DATA_W-1:0] z_hi);
        drain_results();
        write_reg($urandom_range(REG_ZERO_MAX + 1, 15), $urandom);
        write_reg(REG_HEADER_MIN, h_lo);
        write_reg(REG_HEADER_MAX, h_hi);
        write_reg(REG_REPEAT_MIN, r_lo);
        write_reg(REG_REPEAT_MAX, r_hi);
        write_reg(REG_ONE_MIN, o_lo);
        write_reg(REG_ONE_MAX, o_hi);
        write_reg(REG_ZERO_MIN, z_lo);
        write_reg(REG_ZERO_MAX, z_hi);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_window_edges();
        logic [PULSE_W-1:0] widths [$];
        widths = '{16'd0, 16'hFFFF,
                   REPEAT_MIN_RST, REPEAT_MIN_RST + 16'd1, REPEAT_MAX_RST - 16'd1, REPEAT_MAX_RST,
                   HEADER_MIN_RST, HEADER_MAX_RST, HEADER_MAX_RST - 16'd1,
                   ONE_MIN_RST, ONE_MIN_RST + 16'd1, ONE_MAX_RST - 16'd1, ONE_MAX_RST,
                   ZERO_MIN_RST, ZERO_MIN_RST + 16'd1, ZERO_MAX_RST - 16'd1, ZERO_MAX_RST,
                   HEADER_MIN_RST + 16'd1, REPEAT_MIN_RST + 16'd1, 16'hFFFF, 16'd0};
        foreach (widths[i])
            send_pulse(widths[i]);
        drain_results();
    endtask

    task automatic test_default_frames();
        run_mix(450);
        drain_results();
    endtask

    task automatic test_overlapping_windows();
        set_windows(16'd1500, 16'd2100, 16'd300, 16'd1700, 16'd1400, 16'd1900, 16'd360, 16'd760);
        run_mix(250);
        drain_results();
    endtask

    task automatic test_extreme_windows();
        set_windows(16'd0, 16'd200, 16'hFFFF, 16'd0, 16'd300, 16'hFFFF, 16'd250, 16'd250);
        run_mix(150);
        drain_results();
    endtask

    task automatic test_random_windows();
        logic [CFG_DATA_W-1:0] h;
        logic [CFG_DATA_W-1:0] r;
        logic [CFG_DATA_W-1:0] o;
        logic [CFG_DATA_W-1:0] z;
        repeat (5)
        begin
            h = $urandom;
            r = $urandom;
            o = $urandom;
            z = $urandom;
            set_windows(h, random_upper(h), r, random_upper(r),
                        o, random_upper(o), z, random_upper(z));
            run_mix(80);
        end
        drain_results();
    endtask

    initial
    begin : result_checker
        int       stall;
        decoded_t want;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                receiver_calm = !receiver_calm;
            stall = receiver_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
            if (decoded_q.size() == 0)
            begin
                $error("unexpected item: result_kind %0d device_address %0h command_code %0h",
                       result_ch.result_kind, result_ch.device_address, result_ch.command_code);
                mismatch_count++;
            end
            else
            begin
                want = decoded_q.pop_front();
                if (result_ch.result_kind !== want.kind)
                begin
                    $error("result_kind: expected %0d, actual %0d",
                           want.kind, result_ch.result_kind);
                    mismatch_count++;
                end
                if (result_ch.device_address !== want.address)
                begin
                    $error("device_address: expected %0h, actual %0h",
                           want.address, result_ch.device_address);
                    mismatch_count++;
                end
                if (result_ch.command_code !== want.command)
                begin
                    $error("command_code: expected %0h, actual %0h",
                           want.command, result_ch.command_code);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        reset_model();
        rst_n                <= 1'b0;
        pulse_ch.valid       <= 1'b0;
        pulse_ch.pulse_width <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= '0;
        cfg_ch.data          <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_window_edges();
        test_default_frames();
        test_overlapping_windows();
        test_extreme_windows();
        test_random_windows();
        drain_results();
        if (mismatch_count == 0 && decoded_q.size() == 0)
            $display("nec_ir_frame_decoder regression: pass");
        else
            $display("nec_ir_frame_decoder regression: fail");
        $finish;
    end

endmodule
